// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication assertion, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Clocked next-cycle implication assertion.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/sma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sma_pkg;

  localparam int unsigned NumSectors = 1024;

  localparam logic [15:0] EntFree = 16'h0000;
  localparam logic [15:0] EntCont = 16'hFFFF;

  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpFree    = 2'd1;
  localparam logic [1:0] OpFreeAll = 2'd2;
  localparam logic [1:0] OpChange  = 2'd3;

  localparam logic [1:0] RegSectorBytes = 2'd0;
  localparam logic [1:0] RegFirstSector = 2'd1;
  localparam logic [1:0] RegEndSector   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] owner_id;
    logic [15:0] new_owner_id;
    logic [23:0] request_bytes;
    logic [23:0] byte_offset;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [23:0] alloc_offset;
  } rsp_t;

  // Divider control and status between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quot;
    logic        rem_nz;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StDivWait,
    StCheck,
    StScan,
    StScanRd,
    StFill,
    StHeadRd,
    StHeadChk,
    StClrRd,
    StClrChk,
    StMulHead,
    StDone
  } state_e;

endpackage
`default_nettype wire

// ===== design/sma_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sma_divider (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sma_pkg::div_req_t req_i,
  output sma_pkg::div_rsp_t     rsp_o
);

  logic [23:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], quot_q[23]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd24;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[22:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = (rem_q != '0);

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_done_once, clk_i, rst_ni, done_q, !done_q)
  `ASSERT_IMPL(a_div_busy_cnt, clk_i, rst_ni, busy_q, cnt_q != 5'd0)
  `ASSERT_NEXT(a_div_start, clk_i, rst_ni, req_i.start, busy_q)

endmodule
`default_nettype wire

// ===== design/sma_map_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sector map storage with a clearing sweep after reset.
module sma_map_ram #(
  parameter int unsigned NumSectors = sma_pkg::NumSectors,
  localparam int unsigned AW = $clog2(NumSectors)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [15:0]        rdata_o,
  output logic               init_done_o
);

  logic [15:0] mem [NumSectors];
  logic [AW:0] clr_q;
  logic        clearing;

  assign clearing    = (clr_q != AW'(0) + (AW+1)'(NumSectors));
  assign init_done_o = !clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_q[AW-1:0]] <= sma_pkg::EntFree;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ram_no_wr_clr, clk_i, rst_ni, clearing, !we_i)
  `ASSERT_NEXT(a_ram_clr_mono, clk_i, rst_ni, !clearing, !clearing)

endmodule
`default_nettype wire

// ===== design/sector_map_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake
// cmd       in         start accepted when busy is low
// rsp       out        done_o strobe, one cycle, no back-pressure
// cfg       in         cfg_we_i write, no wait
//
// Allocate and free-all walk the map through the single map RAM, each entry in a
// read state then a check state, and allocate then fills the claimed run entry
// by entry; free walks the run's continuations in read and check states too.
// Byte-to-sector division uses a shared divider. After reset the map is swept
// clear, during which busy stays high. Results cannot be stalled.
module sector_map_allocator_unit #(
  parameter int unsigned NumSectors = sma_pkg::NumSectors
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire sma_pkg::cmd_t cmd_i,
  output logic               done_o,
  output sma_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(NumSectors);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned XW = (IW > 11) ? IW : 11;

  sma_pkg::state_e state_q, state_d;
  sma_pkg::cmd_t   cmd_q, cmd_d;
  logic [15:0] sb_q;
  logic [10:0] fs_q, es_q;
  logic [XW-1:0] idx_q, idx_d, head_q, head_d, run_q, run_d;
  logic [23:0] need_q, need_d;
  logic        inrun_q, inrun_d;
  logic        st_q, st_d;
  logic [23:0] off_q, off_d;
  logic        done_q, done_d;
  logic [39:0] prod;

  logic [XW-1:0] uend, fsx;
  logic          id_ok, nid_ok;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic          init_done;

  sma_pkg::div_req_t dreq;
  sma_pkg::div_rsp_t drsp;

  sma_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  sma_map_ram #(.NumSectors(NumSectors)) u_ram (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata), .init_done_o(init_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= 16'd256;
      fs_q <= 11'd1;
      es_q <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sma_pkg::RegSectorBytes: sb_q <= cfg_data_i;
        sma_pkg::RegFirstSector: fs_q <= cfg_data_i[10:0];
        sma_pkg::RegEndSector:   es_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign fsx    = XW'(fs_q);
  assign uend   = (XW'(es_q) < XW'(NumSectors)) ? XW'(es_q) : XW'(NumSectors);
  assign id_ok  = cmd_q.owner_id != sma_pkg::EntFree && cmd_q.owner_id != sma_pkg::EntCont;
  assign nid_ok = cmd_q.new_owner_id != sma_pkg::EntFree &&
                  cmd_q.new_owner_id != sma_pkg::EntCont;
  // One multiplier, used for the offset range check and the result offset.
  always_comb begin
    prod = 40'(XW'(0));
    unique case (state_q)
      sma_pkg::StCheck: prod = 40'(need_q) * 40'(sb_q);
      default:          prod = 40'(head_q) * 40'(sb_q);
    endcase
  end

  assign busy = (state_q != sma_pkg::StIdle) || !init_done;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    head_d  = head_q;
    run_d   = run_q;
    need_d  = need_q;
    inrun_d = inrun_q;
    st_d    = st_q;
    off_d   = off_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = sma_pkg::EntFree;
    raddr   = idx_q[AW-1:0];
    dreq    = '{start: 1'b0, dividend: '0, divisor: sb_q};
    unique case (state_q)
      sma_pkg::StIdle: begin
        if (start && init_done) begin
          cmd_d   = cmd_i;
          st_d    = 1'b1;
          off_d   = '0;
          state_d = sma_pkg::StDiv;
        end
      end
      sma_pkg::StDiv: begin
        if (cmd_q.op == sma_pkg::OpFreeAll) begin
          st_d    = !id_ok;
          idx_d   = fsx;
          inrun_d = 1'b0;
          state_d = id_ok ? sma_pkg::StScanRd : sma_pkg::StDone;
        end else if (!id_ok || sb_q == '0 || fsx >= uend ||
                     (cmd_q.op == sma_pkg::OpChange && !nid_ok) ||
                     (cmd_q.op == sma_pkg::OpAlloc && cmd_q.request_bytes == '0)) begin
          state_d = sma_pkg::StDone;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = (cmd_q.op == sma_pkg::OpAlloc) ? cmd_q.request_bytes
                                                         : cmd_q.byte_offset;
          state_d = sma_pkg::StDivWait;
        end
      end
      sma_pkg::StDivWait: begin
        if (drsp.done) begin
          if (cmd_q.op == sma_pkg::OpAlloc) begin
            need_d  = drsp.quot + 24'(drsp.rem_nz);
            idx_d   = fsx;
            run_d   = '0;
            state_d = sma_pkg::StScanRd;
          end else begin
            // Offset in range iff first <= quotient < end.
            if (drsp.quot >= 24'(fsx) && drsp.quot < 24'(uend)) begin
              head_d  = XW'(drsp.quot);
              idx_d   = XW'(drsp.quot);
              state_d = sma_pkg::StHeadRd;
            end else begin
              state_d = sma_pkg::StDone;
            end
          end
        end
      end
      sma_pkg::StScanRd: begin
        if (idx_q >= uend) begin
          state_d = sma_pkg::StDone;
        end else begin
          state_d = sma_pkg::StScan;
        end
      end
      sma_pkg::StScan: begin
        if (cmd_q.op == sma_pkg::OpFreeAll) begin
          if (rdata == cmd_q.owner_id) begin
            we = 1'b1;
            inrun_d = 1'b1;
          end else if (rdata == sma_pkg::EntCont && inrun_q) begin
            we = 1'b1;
          end else begin
            inrun_d = 1'b0;
          end
          idx_d   = idx_q + XW'(1);
          state_d = sma_pkg::StScanRd;
        end else begin
          if (rdata == sma_pkg::EntFree) begin
            run_d = run_q + XW'(1);
            if (24'(run_q) + 24'd1 == need_q) begin
              head_d  = idx_q + XW'(1) - (run_q + XW'(1));
              state_d = sma_pkg::StMulHead;
            end else begin
              idx_d   = idx_q + XW'(1);
              state_d = sma_pkg::StScanRd;
            end
          end else begin
            run_d   = '0;
            idx_d   = idx_q + XW'(1);
            state_d = sma_pkg::StScanRd;
          end
        end
      end
      sma_pkg::StMulHead: begin
        if (prod > 40'hFFFFFF) begin
          state_d = sma_pkg::StDone;
        end else begin
          off_d   = prod[23:0];
          idx_d   = head_q;
          state_d = sma_pkg::StFill;
        end
      end
      sma_pkg::StFill: begin
        we    = 1'b1;
        wdata = (idx_q == head_q) ? cmd_q.owner_id : sma_pkg::EntCont;
        idx_d = idx_q + XW'(1);
        if (idx_q - head_q + XW'(1) == run_q) begin
          st_d    = 1'b0;
          state_d = sma_pkg::StDone;
        end
      end
      sma_pkg::StHeadRd: state_d = sma_pkg::StHeadChk;
      sma_pkg::StHeadChk: begin
        if (rdata != cmd_q.owner_id) begin
          state_d = sma_pkg::StDone;
        end else begin
          we    = 1'b1;
          st_d  = 1'b0;
          wdata = (cmd_q.op == sma_pkg::OpChange) ? cmd_q.new_owner_id : sma_pkg::EntFree;
          idx_d = idx_q + XW'(1);
          state_d = (cmd_q.op == sma_pkg::OpChange) ? sma_pkg::StDone : sma_pkg::StClrRd;
        end
      end
      sma_pkg::StClrRd: begin
        state_d = (idx_q >= uend) ? sma_pkg::StDone : sma_pkg::StClrChk;
      end
      sma_pkg::StClrChk: begin
        if (rdata == sma_pkg::EntCont) begin
          we      = 1'b1;
          idx_d   = idx_q + XW'(1);
          state_d = sma_pkg::StClrRd;
        end else begin
          state_d = sma_pkg::StDone;
        end
      end
      sma_pkg::StDone: begin
        done_d  = 1'b1;
        state_d = sma_pkg::StIdle;
      end
      default: state_d = sma_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sma_pkg::StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    head_q  <= head_d;
    run_q   <= run_d;
    need_q  <= need_d;
    inrun_q <= inrun_d;
    st_q    <= st_d;
    off_q   <= off_d;
  end

  assign done_o             = done_q;
  assign rsp_o.status       = st_q;
  assign rsp_o.alloc_offset = st_q ? 24'd0 : off_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_top_done_idle, clk_i, rst_ni, done_q, state_q == sma_pkg::StIdle)
  `ASSERT_IMPL(a_top_busy_done, clk_i, rst_ni, done_q, !busy || !init_done)
  `ASSERT_IMPL(a_top_fail_zero, clk_i, rst_ni, done_q && st_q, rsp_o.alloc_offset == 24'd0)

endmodule
`default_nettype wire
